>>> rtl/indexed_list_store_unit_macros.svh
// Assertion macros for the indexed list store unit.
// Used by the top level; needs a clock and an active-low reset in scope of each use.
`ifndef INDEXED_LIST_STORE_UNIT_MACROS_SVH
`define INDEXED_LIST_STORE_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define ILSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ilsu: same-cycle check failed");

// next-cycle implication, masked during reset
`define ILSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ilsu: next-cycle check failed");

`endif

>>> rtl/ilsu_pkg.sv
// Package for the indexed list store unit: field widths, request codes, status codes,
// queue entry and sequencer state types. No dependencies.
`timescale 1ns / 1ps

package ilsu_pkg;

    localparam int OP_W     = 3;
    localparam int IDX_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_READ      = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_APPEND    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_INS_FRONT,
        CMD_APPEND,
        CMD_REMOVE,
        CMD_DUMP,
        CMD_BAD
    } t_cmd;

    typedef struct packed {
        t_cmd                    cmd;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] item_value;
    } t_cmd_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_UNLINK,
        S_APPEND,
        S_DUMP
    } t_state;

endpackage

>>> rtl/ilsu_req_if.sv
// Request channel of the indexed list store unit: valid/ready plus request payload.
// Depends on ilsu_pkg.
`timescale 1ns / 1ps

interface ilsu_req_if;
    import ilsu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] item_value;

    modport source (output valid, output opcode, output index, output item_value,
                    input ready);
    modport sink   (input valid, input opcode, input index, input item_value,
                    output ready);
endinterface

>>> rtl/ilsu_rsp_if.sv
// Response channel of the indexed list store unit: valid/ready plus result payload.
// Depends on ilsu_pkg.
`timescale 1ns / 1ps

interface ilsu_rsp_if;
    import ilsu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] read_value;
    logic                    last;

    modport source (output valid, output status, output read_value, output last,
                    input ready);
    modport sink   (input valid, input status, input read_value, input last,
                    output ready);
endinterface

>>> rtl/ilsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ilsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> rtl/ilsu_front.sv
// Front end: accepts requests, decodes the opcode into a command and queues it
// for the sequencer. Depends on ilsu_pkg and ilsu_req_if.
`timescale 1ns / 1ps

module ilsu_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ilsu_req_if.sink            i_req,
    output logic                o_cmd_valid,
    output ilsu_pkg::t_cmd_entry o_cmd,
    input  logic                i_cmd_pop
);
    import ilsu_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    t_cmd_entry       r_queue [QDEPTH];
    logic [QPW-1:0]   r_wptr;
    logic [QPW-1:0]   r_rptr;
    logic [QCW-1:0]   r_fill;
    logic [QPW-1:0]   n_wptr;
    logic [QPW-1:0]   n_rptr;
    logic [QCW-1:0]   n_fill;
    logic             push;
    logic             pop;
    t_cmd             dec_cmd;
    t_cmd_entry       push_entry;

    always_comb begin
        unique case (i_req.opcode)
            OP_READ:      dec_cmd = CMD_READ;
            OP_INS_FRONT: dec_cmd = CMD_INS_FRONT;
            OP_APPEND:    dec_cmd = CMD_APPEND;
            OP_REMOVE:    dec_cmd = CMD_REMOVE;
            OP_DUMP:      dec_cmd = CMD_DUMP;
            default:      dec_cmd = CMD_BAD;
        endcase
    end

    assign push_entry = '{cmd: dec_cmd, index: i_req.index, item_value: i_req.item_value};

    assign i_req.ready = (r_fill != QCW'(QDEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_queue[r_rptr];

    always_comb begin
        n_wptr = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = pop ? r_rptr + 1'b1 : r_rptr;
        n_fill = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wptr] <= push_entry;
        end
    end
endmodule

>>> rtl/ilsu_back.sv
// Back end: sequencer that carries out queued commands on the linked node pool
// and holds the result register. Depends on ilsu_pkg, ilsu_rsp_if and ilsu_ram.
`timescale 1ns / 1ps

module ilsu_back #(
    parameter int CAPACITY = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  ilsu_pkg::t_cmd_entry i_cmd,
    output logic                 o_cmd_pop,
    ilsu_rsp_if.source           o_rsp
);
    import ilsu_pkg::*;

    localparam int W  = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state                  r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [W-1:0]            r_cur, n_cur;
    logic [W-1:0]            r_left, n_left;
    logic [W-1:0]            r_prev, n_prev;
    logic [W-1:0]            r_new, n_new;
    logic [W-1:0]            r_front, n_front;
    logic [W-1:0]            r_back, n_back;
    logic [CW-1:0]           r_count, n_count;
    logic [CAPACITY-1:0]     r_free, n_free;

    logic                    r_rsp_valid;
    logic [STATUS_W-1:0]     r_rsp_status;
    logic signed [VAL_W-1:0] r_rsp_value;
    logic                    r_rsp_last;

    logic                    out_free;
    logic                    idx_miss;
    logic                    is_empty;
    logic                    is_full;
    logic                    walk_done;
    logic                    head_rm;
    logic [CAPACITY-1:0]     free_low;
    logic [CAPACITY-1:0]     cur_bit;
    logic [W-1:0]            new_slot;

    logic [W-1:0]            rd_addr;
    logic signed [VAL_W-1:0] val_rd;
    logic [W-1:0]            lnk_rd;
    logic                    val_wr_en;
    logic [W-1:0]            val_wr_addr;
    logic signed [VAL_W-1:0] val_wr_data;
    logic                    lnk_wr_en;
    logic [W-1:0]            lnk_wr_addr;
    logic [W-1:0]            lnk_wr_data;

    logic                    emit;
    logic [STATUS_W-1:0]     emit_status;
    logic signed [VAL_W-1:0] emit_value;
    logic                    emit_last;

    ilsu_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_values (
        .i_clk     (i_clk),
        .i_wr_en   (val_wr_en),
        .i_wr_addr (val_wr_addr),
        .i_wr_data (val_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (val_rd)
    );

    ilsu_ram #(.WIDTH(W), .DEPTH(CAPACITY)) u_links (
        .i_clk     (i_clk),
        .i_wr_en   (lnk_wr_en),
        .i_wr_addr (lnk_wr_addr),
        .i_wr_data (lnk_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (lnk_rd)
    );

    assign out_free  = !r_rsp_valid || o_rsp.ready;
    assign idx_miss  = (r_idx >= IDX_W'(r_count));
    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count == CW'(CAPACITY));
    assign walk_done = (r_left == '0);
    assign head_rm   = (r_idx == '0);
    assign cur_bit   = {{(CAPACITY-1){1'b0}}, 1'b1} << r_cur;

    // lowest free slot: isolate lowest set bit, then encode
    assign free_low = r_free & (~r_free + 1'b1);
    always_comb begin
        new_slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (free_low[i]) begin
                new_slot = new_slot | W'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (r_cmd)
                    CMD_READ, CMD_REMOVE: begin
                        if (!idx_miss) begin
                            n_state = S_WALK;
                        end else if (out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    CMD_APPEND: begin
                        if (!is_full && !is_empty) begin
                            n_state = S_APPEND;
                        end else if (out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    CMD_DUMP: begin
                        if (!is_empty) begin
                            n_state = S_DUMP;
                        end else if (out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_WALK: begin
                if (walk_done) begin
                    if (r_cmd == CMD_REMOVE && !head_rm) begin
                        n_state = S_UNLINK;
                    end else if (out_free) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_UNLINK, S_APPEND: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free && walk_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_val       = r_val;
        n_left      = r_left;
        n_prev      = r_prev;
        n_new       = r_new;
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_free      = r_free;
        rd_addr     = r_cur;
        o_cmd_pop   = 1'b0;
        val_wr_en   = 1'b0;
        val_wr_addr = new_slot;
        val_wr_data = r_val;
        lnk_wr_en   = 1'b0;
        lnk_wr_addr = new_slot;
        lnk_wr_data = '0;
        emit        = 1'b0;
        emit_status = STATUS_MISS;
        emit_value  = MISS_VALUE;
        emit_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd.cmd;
                    n_idx = i_cmd.index;
                    n_val = i_cmd.item_value;
                end
            end
            S_DISPATCH: begin
                unique case (r_cmd)
                    CMD_READ, CMD_REMOVE: begin
                        if (idx_miss) begin
                            emit = out_free;
                        end else begin
                            rd_addr = r_front;
                            if (r_cmd == CMD_REMOVE && !head_rm) begin
                                n_left = W'(r_idx - 1'b1);
                            end else begin
                                n_left = W'(r_idx);
                            end
                        end
                    end
                    CMD_INS_FRONT: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (is_full) begin
                                emit_status = STATUS_FULL;
                            end else begin
                                emit_status = STATUS_DONE;
                                emit_value  = '0;
                                val_wr_en   = 1'b1;
                                lnk_wr_en   = 1'b1;
                                lnk_wr_data = is_empty ? '0 : r_front;
                                n_front     = new_slot;
                                if (is_empty) begin
                                    n_back = new_slot;
                                end
                                n_count = r_count + 1'b1;
                                n_free  = r_free & ~free_low;
                            end
                        end
                    end
                    CMD_APPEND: begin
                        if (is_full) begin
                            emit        = out_free;
                            emit_status = STATUS_FULL;
                        end else if (is_empty) begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_status = STATUS_DONE;
                                emit_value  = '0;
                                val_wr_en   = 1'b1;
                                lnk_wr_en   = 1'b1;
                                n_front     = new_slot;
                                n_back      = new_slot;
                                n_count     = r_count + 1'b1;
                                n_free      = r_free & ~free_low;
                            end
                        end else begin
                            // new tail node now; old tail is linked in S_APPEND once the output register is free
                            val_wr_en = 1'b1;
                            lnk_wr_en = 1'b1;
                            n_new     = new_slot;
                            n_free    = r_free & ~free_low;
                        end
                    end
                    CMD_DUMP: begin
                        if (is_empty) begin
                            emit = out_free;
                        end else begin
                            rd_addr = r_front;
                            n_left  = W'(r_count - 1'b1);
                        end
                    end
                    default: begin
                        emit = out_free;
                    end
                endcase
            end
            S_WALK: begin
                if (!walk_done) begin
                    rd_addr = lnk_rd;
                    n_left  = r_left - 1'b1;
                end else if (r_cmd == CMD_READ) begin
                    emit        = out_free;
                    emit_status = STATUS_DONE;
                    emit_value  = val_rd;
                end else if (head_rm) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = STATUS_DONE;
                        emit_value  = '0;
                        n_front     = lnk_rd;
                        if (r_count == CW'(1)) begin
                            n_back = lnk_rd;
                        end
                        n_count = r_count - 1'b1;
                        n_free  = r_free | cur_bit;
                    end
                end else begin
                    // r_cur is the predecessor; fetch the victim's link
                    n_prev  = r_cur;
                    rd_addr = lnk_rd;
                end
            end
            S_UNLINK: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = STATUS_DONE;
                    emit_value  = '0;
                    lnk_wr_en   = 1'b1;
                    lnk_wr_addr = r_prev;
                    lnk_wr_data = lnk_rd;
                    if (r_cur == r_back) begin
                        n_back = r_prev;
                    end
                    n_count = r_count - 1'b1;
                    n_free  = r_free | cur_bit;
                end
            end
            S_APPEND: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = STATUS_DONE;
                    emit_value  = '0;
                    lnk_wr_en   = 1'b1;
                    lnk_wr_addr = r_back;
                    lnk_wr_data = r_new;
                    n_back      = r_new;
                    n_count     = r_count + 1'b1;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = STATUS_DONE;
                    emit_value  = val_rd;
                    emit_last   = walk_done;
                    if (!walk_done) begin
                        rd_addr = lnk_rd;
                        n_left  = r_left - 1'b1;
                    end
                end
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase

        n_cur = rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_free      <= '1;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            r_free  <= n_free;
            if (emit) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_cur  <= n_cur;
        r_left <= n_left;
        r_prev <= n_prev;
        r_new  <= n_new;
        if (emit) begin
            r_rsp_status <= emit_status;
            r_rsp_value  <= emit_value;
            r_rsp_last   <= emit_last;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.status     = r_rsp_status;
    assign o_rsp.read_value = r_rsp_value;
    assign o_rsp.last       = r_rsp_last;
endmodule

>>> rtl/indexed_list_store_unit.sv
// Indexed list store unit: top level joining the request front end and the sequencer.
// Depends on ilsu_pkg, ilsu_req_if, ilsu_rsp_if, ilsu_front, ilsu_back and the macro header.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a pool of node slots
// joined by links held in a registered-read memory. Requests are taken into a two-entry
// queue and carried out one at a time; each produces one result with last set, except a
// dump of a non-empty list, which gives one result per value in list order. Every link
// hop is one read of the link memory. Results wait in an output register, and the queue
// keeps taking requests while one is stalled, until it is full. No clearing pass is
// needed after reset.
`timescale 1ns / 1ps
`include "indexed_list_store_unit_macros.svh"

module indexed_list_store_unit #(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilsu_req_if.sink    i_req,
    ilsu_rsp_if.source  o_rsp
);
    import ilsu_pkg::*;

    logic       cmd_valid;
    logic       cmd_pop;
    t_cmd_entry cmd;
    logic       rsp_fail;
    logic       rsp_fail_form;

    ilsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ilsu_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );

    assign rsp_fail      = o_rsp.valid && (o_rsp.status != STATUS_DONE);
    assign rsp_fail_form = (o_rsp.read_value == MISS_VALUE) && o_rsp.last &&
                           (o_rsp.status == STATUS_MISS || o_rsp.status == STATUS_FULL);

    `ILSU_ASSERT_IMP(a_pop_needs_entry, i_clk, i_rst_n, cmd_pop, cmd_valid)
    `ILSU_ASSERT_NXT(a_one_request_at_a_time, i_clk, i_rst_n, cmd_pop, !cmd_pop)
    `ILSU_ASSERT_IMP(a_full_queue_pending, i_clk, i_rst_n, !i_req.ready, cmd_valid)
    `ILSU_ASSERT_IMP(a_fail_result_form, i_clk, i_rst_n, rsp_fail, rsp_fail_form)
endmodule
